### hdl/mfa_pkg.sv
// Shared types, constants and small lookup functions for the face area block.
// Used by mfa_front, mfa_back and mesh_face_area; depends on nothing.
`default_nettype none
package mfa_pkg;

  localparam int AREA_W        = 48;
  localparam int VIDX_W        = 3;
  localparam int INV_SQRT3_Q16 = 37837;
  localparam int TRI_SHIFT     = 1;
  localparam int QUAD_SHIFT    = 20;

  // area rule picked from the node count
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_TRI,
    MODE_HEX,
    MODE_QUAD
  } mode_t;

  typedef struct packed {
    logic  last;
    mode_t mode;
  } tag_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CROSS,
    ST_SCALE,
    ST_SQUARE,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SG_ZERO,
    SG_ADD,
    SG_SUB
  } sign_t;

  typedef struct packed {
    sign_t a;
    sign_t b;
    sign_t c;
  } ld_sign_t;

  function automatic mode_t classify(input logic [3:0] nodes);
    mode_t m;
    case (nodes)
      4'd3, 4'd7: m = MODE_TRI;
      4'd6:       m = MODE_HEX;
      4'd4:       m = MODE_QUAD;
      default:    m = MODE_NONE;
    endcase
    return m;
  endfunction

  // vertex read for load step k of sub-triangle t
  function automatic logic [VIDX_W-1:0] ld_addr(input mode_t m, input logic [1:0] t,
                                                input logic [1:0] k);
    logic [VIDX_W-1:0] a;
    a = VIDX_W'(k);
    if (m == MODE_HEX) begin
      case ({t, k})
        4'b00_00: a = 3'd0;
        4'b00_01: a = 3'd3;
        4'b00_10: a = 3'd5;
        4'b01_00: a = 3'd3;
        4'b01_01: a = 3'd1;
        4'b01_10: a = 3'd4;
        4'b10_00: a = 3'd2;
        4'b10_01: a = 3'd5;
        4'b10_10: a = 3'd4;
        4'b11_00: a = 3'd3;
        4'b11_01: a = 3'd4;
        4'b11_10: a = 3'd5;
        default:  a = 3'd0;
      endcase
    end
    return a;
  endfunction

  // how load step k folds into the operand vectors
  function automatic ld_sign_t ld_sign(input mode_t m, input logic [1:0] k);
    ld_sign_t s;
    s = '{a: SG_ZERO, b: SG_ZERO, c: SG_ZERO};
    if (m == MODE_QUAD) begin
      case (k)
        2'd0:    s = '{a: SG_SUB, b: SG_SUB, c: SG_ADD};
        2'd1:    s = '{a: SG_ADD, b: SG_SUB, c: SG_SUB};
        2'd2:    s = '{a: SG_ADD, b: SG_ADD, c: SG_ADD};
        default: s = '{a: SG_SUB, b: SG_ADD, c: SG_SUB};
      endcase
    end else begin
      case (k)
        2'd0:    s = '{a: SG_SUB, b: SG_SUB, c: SG_ZERO};
        2'd1:    s = '{a: SG_ADD, b: SG_ZERO, c: SG_ZERO};
        2'd2:    s = '{a: SG_ZERO, b: SG_ADD, c: SG_ZERO};
        default: s = '{a: SG_ZERO, b: SG_ZERO, c: SG_ZERO};
      endcase
    end
    return s;
  endfunction

endpackage
`default_nettype wire

### hdl/mfa_front.sv
// Front end: accepts vertex words, classifies the node count, queues items.
// Depends on mfa_pkg.
`default_nettype none
module mfa_front #(
  parameter int C = 24
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_vld,
  output logic                 in_rdy,
  input  wire logic [3*C-1:0]  in_xyz,
  input  wire logic [3:0]      in_nodes,
  input  wire logic            in_last,
  output logic                 q_vld,
  input  wire logic            q_pop,
  output logic [3*C-1:0]       q_xyz,
  output mfa_pkg::tag_t        q_tag
);

  logic [3*C-1:0] xyz_r [2];
  mfa_pkg::tag_t  tag_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           push;

  assign in_rdy = (cnt_r != 2'd2);
  assign push   = in_vld && in_rdy;
  assign q_vld  = (cnt_r != 2'd0);
  assign q_xyz  = xyz_r[rd_ptr_r];
  assign q_tag  = tag_r[rd_ptr_r];

  // store incoming word with its rule
  always_ff @(posedge clk) begin
    if (push) begin
      xyz_r[wr_ptr_r] <= in_xyz;
      tag_r[wr_ptr_r] <= '{last: in_last, mode: mfa_pkg::classify(in_nodes)};
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop && q_vld) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop && q_vld);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_vld) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !in_rdy) else $error("accept while full");
`endif

endmodule
`default_nettype wire

### hdl/mfa_mul.sv
// Serial shift-add signed multiplier, one multiplier bit per cycle.
// Standalone; used by mfa_back.
`default_nettype none
module mfa_mul #(
  parameter int W = 70
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic signed [W-1:0] a,
  input  wire logic signed [W-1:0] b,
  output logic                     done,
  output logic signed [2*W-1:0]    p
);

  localparam int CW = $clog2(W + 1);

  logic [2*W-1:0] mcand_r, prod_r, prod_nxt;
  logic [W-1:0]   mplier_r;
  logic [CW-1:0]  cnt_r;
  logic           neg_r, busy_r, done_r;
  logic [2*W-1:0] p_r;

  assign prod_nxt = prod_r + (mplier_r[0] ? mcand_r : '0);
  assign done     = done_r;
  assign p        = $signed(p_r);

  // hold operands and shift one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r    <= a[W-1] ^ b[W-1];
      mcand_r  <= {{W{1'b0}}, (a[W-1] ? -a : a)};
      mplier_r <= b[W-1] ? -b : b;
      prod_r   <= '0;
    end else if (busy_r) begin
      prod_r   <= prod_nxt;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
      if (cnt_r == CW'(1)) p_r <= neg_r ? -prod_nxt : prod_nxt;
    end
  end

  // count steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hdl/mfa_root.sv
// Bit-serial integer square root, one root bit per cycle.
// Standalone; used by mfa_back.
`default_nettype none
module mfa_root #(
  parameter int RW = 70
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [2*RW-1:0] n,
  output logic                 done,
  output logic [RW-1:0]        root
);

  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] rad_r;
  logic [RW+1:0]   rem_r, rem2, trial;
  logic [RW-1:0]   root_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r, done_r;
  logic            fit;

  assign rem2  = {rem_r[RW-1:0], rad_r[2*RW-1:2*RW-2]};
  assign trial = {root_r, 2'b01};
  assign fit   = (rem2 >= trial);
  assign done  = done_r;
  assign root  = root_r;

  // take two radicand bits a step
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= n;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= fit ? rem2 - trial : rem2;
      root_r <= {root_r[RW-2:0], fit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hdl/mfa_back.sv
// Back end: vertex store, sequencer over cross products, norms and roots.
// Depends on mfa_pkg, mfa_mul and mfa_root.
`default_nettype none
module mfa_back #(
  parameter int N = 6,
  parameter int C = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_vld,
  output logic                             q_pop,
  input  wire logic [3*C-1:0]              q_xyz,
  input  wire mfa_pkg::tag_t               q_tag,
  input  wire logic                        res_rdy,
  output logic                             res_vld,
  output logic [mfa_pkg::AREA_W-1:0]       res_area,
  output logic                             res_unsup,
  output logic                             res_sat
);

  localparam int D  = C + 2;
  localparam int XW = 2 * C + 4;
  localparam int YW = 2 * C + 22;
  localparam int SW = 2 * YW;
  localparam int AW = YW + 3;
  localparam int IW = $clog2(N);
  localparam int NW = $clog2(N + 1);
  localparam int AREA_W = mfa_pkg::AREA_W;

  mfa_pkg::state_t state_r, state_nxt;
  mfa_pkg::mode_t  mode_r;

  logic [3*C-1:0]       store_mem [N];
  logic [3*C-1:0]       rd_data_r;
  logic [IW-1:0]        rd_addr;
  logic [NW-1:0]        cnt_r;

  logic signed [D-1:0]  opa_r [3];
  logic signed [D-1:0]  opb_r [3];
  logic signed [D-1:0]  opc_r [3];
  logic signed [XW-1:0] pv_r [3];
  logic signed [XW-1:0] qv_r [3];
  logic signed [XW-1:0] rv_r [3];
  logic signed [XW-1:0] tmp_r;
  logic signed [YW-1:0] y_r;
  logic [SW-1:0]        sumsq_r;
  logic [AW-1:0]        acc_r;

  logic [1:0] ld_r, tri_r, ci_r, k_r, pt_r;
  logic       ph_r, t_r, busy_r;

  logic                 mul_start, root_start, mul_done, root_done;
  logic signed [YW-1:0] mul_a, mul_b;
  logic signed [SW-1:0] mul_p;
  logic [YW-1:0]        root_val;

  logic                 quad, last_ld;
  logic [1:0]           j, kk;
  logic signed [D-1:0]  xs, ys;
  logic signed [XW:0]   qr;
  logic signed [YW-1:0] p_ext;
  mfa_pkg::ld_sign_t    sg;
  logic signed [D-1:0]  vx, vy, vz;
  logic [AW-1:0]        shifted;
  logic                 over;

  logic                  res_vld_r, res_unsup_r, res_sat_r;
  logic [AREA_W-1:0]     res_area_r;

  assign quad    = (mode_r == mfa_pkg::MODE_QUAD);
  assign last_ld = quad ? (ld_r == 2'd3) : (ld_r == 2'd2);
  assign rd_addr = IW'(mfa_pkg::ld_addr(mode_r, tri_r, ld_r));
  assign sg      = mfa_pkg::ld_sign(mode_r, ld_r);
  assign vx      = D'($signed(rd_data_r[C-1:0]));
  assign vy      = D'($signed(rd_data_r[2*C-1:C]));
  assign vz      = D'($signed(rd_data_r[3*C-1:2*C]));
  assign j       = (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
  assign kk      = (k_r == 2'd0) ? 2'd2 : k_r - 2'd1;
  assign p_ext   = YW'(pv_r[k_r]);

  // pick multiplier operands for the current step
  always_comb begin
    xs    = (ci_r == 2'd2) ? opc_r[t_r ? kk : j] : opa_r[t_r ? kk : j];
    ys    = (ci_r == 2'd1) ? opc_r[t_r ? j : kk] : opb_r[t_r ? j : kk];
    qr    = ((pt_r == 2'd1 || pt_r == 2'd2) ? (XW+1)'(qv_r[k_r]) : -(XW+1)'(qv_r[k_r]))
          + ((pt_r == 2'd2 || pt_r == 2'd3) ? (XW+1)'(rv_r[k_r]) : -(XW+1)'(rv_r[k_r]));
    mul_a = YW'(xs);
    mul_b = YW'(ys);
    case (state_r)
      mfa_pkg::ST_SCALE: begin
        mul_a = YW'(mfa_pkg::INV_SQRT3_Q16);
        mul_b = YW'(qr);
      end
      mfa_pkg::ST_SQUARE: begin
        mul_a = quad ? y_r : p_ext;
        mul_b = quad ? y_r : p_ext;
      end
      default: ;
    endcase
  end

  // next state and unit strobes
  always_comb begin
    state_nxt  = state_r;
    q_pop      = 1'b0;
    mul_start  = 1'b0;
    root_start = 1'b0;
    case (state_r)
      mfa_pkg::ST_IDLE: begin
        if (q_vld) begin
          q_pop = 1'b1;
          if (q_tag.last) begin
            state_nxt = (q_tag.mode == mfa_pkg::MODE_NONE) ? mfa_pkg::ST_DONE
                                                            : mfa_pkg::ST_LOAD;
          end
        end
      end
      mfa_pkg::ST_LOAD: begin
        if (ph_r && last_ld) state_nxt = mfa_pkg::ST_CROSS;
      end
      mfa_pkg::ST_CROSS: begin
        mul_start = !busy_r;
        if (mul_done && t_r && k_r == 2'd2 && (!quad || ci_r == 2'd2)) begin
          state_nxt = quad ? mfa_pkg::ST_SCALE : mfa_pkg::ST_SQUARE;
        end
      end
      mfa_pkg::ST_SCALE: begin
        mul_start = !busy_r;
        if (mul_done) state_nxt = mfa_pkg::ST_SQUARE;
      end
      mfa_pkg::ST_SQUARE: begin
        mul_start = !busy_r;
        if (mul_done) begin
          if (k_r == 2'd2)  state_nxt = mfa_pkg::ST_ROOT;
          else if (quad)    state_nxt = mfa_pkg::ST_SCALE;
        end
      end
      mfa_pkg::ST_ROOT: begin
        root_start = !busy_r;
        if (root_done) begin
          if (quad && pt_r != 2'd3) state_nxt = mfa_pkg::ST_SCALE;
          else if (mode_r == mfa_pkg::MODE_HEX && tri_r != 2'd3) state_nxt = mfa_pkg::ST_LOAD;
          else state_nxt = mfa_pkg::ST_DONE;
        end
      end
      mfa_pkg::ST_DONE: begin
        if (!res_vld_r || res_rdy) state_nxt = mfa_pkg::ST_IDLE;
      end
      default: state_nxt = mfa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mfa_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // vertex store
  always_ff @(posedge clk) begin
    if (q_pop && cnt_r < NW'(N)) store_mem[cnt_r[IW-1:0]] <= q_xyz;
    rd_data_r <= store_mem[rd_addr];
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      mode_r <= mfa_pkg::MODE_NONE;
      ld_r <= '0; ph_r <= 1'b0; tri_r <= '0; ci_r <= '0;
      k_r  <= '0; t_r <= 1'b0; pt_r <= '0;
    end else begin
      if (mul_start || root_start)    busy_r <= 1'b1;
      else if (mul_done || root_done) busy_r <= 1'b0;
      case (state_r)
        mfa_pkg::ST_IDLE: begin
          if (q_pop) begin
            if (q_tag.last) begin
              cnt_r  <= '0;
              mode_r <= q_tag.mode;
              ld_r <= '0; ph_r <= 1'b0; tri_r <= '0; ci_r <= '0;
              k_r  <= '0; t_r <= 1'b0; pt_r <= '0;
            end else if (cnt_r < NW'(N)) begin
              cnt_r <= cnt_r + NW'(1);
            end
          end
        end
        mfa_pkg::ST_LOAD: begin
          ph_r <= ~ph_r;
          if (ph_r) ld_r <= last_ld ? 2'd0 : ld_r + 2'd1;
        end
        mfa_pkg::ST_CROSS: begin
          if (mul_done) begin
            t_r <= ~t_r;
            if (t_r) begin
              k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
              if (k_r == 2'd2) ci_r <= ci_r + 2'd1;
            end
          end
        end
        mfa_pkg::ST_SQUARE: begin
          if (mul_done) k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
        end
        mfa_pkg::ST_ROOT: begin
          if (root_done) begin
            pt_r <= pt_r + 2'd1;
            if (mode_r == mfa_pkg::MODE_HEX) begin
              tri_r <= tri_r + 2'd1;
              ci_r  <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      mfa_pkg::ST_IDLE: begin
        acc_r   <= '0;
        sumsq_r <= '0;
        for (int i = 0; i < 3; i++) begin
          opa_r[i] <= '0; opb_r[i] <= '0; opc_r[i] <= '0;
        end
      end
      mfa_pkg::ST_LOAD: begin
        if (ph_r) begin
          opa_r[0] <= (sg.a == mfa_pkg::SG_ADD) ? opa_r[0] + vx :
                      (sg.a == mfa_pkg::SG_SUB) ? opa_r[0] - vx : opa_r[0];
          opa_r[1] <= (sg.a == mfa_pkg::SG_ADD) ? opa_r[1] + vy :
                      (sg.a == mfa_pkg::SG_SUB) ? opa_r[1] - vy : opa_r[1];
          opa_r[2] <= (sg.a == mfa_pkg::SG_ADD) ? opa_r[2] + vz :
                      (sg.a == mfa_pkg::SG_SUB) ? opa_r[2] - vz : opa_r[2];
          opb_r[0] <= (sg.b == mfa_pkg::SG_ADD) ? opb_r[0] + vx :
                      (sg.b == mfa_pkg::SG_SUB) ? opb_r[0] - vx : opb_r[0];
          opb_r[1] <= (sg.b == mfa_pkg::SG_ADD) ? opb_r[1] + vy :
                      (sg.b == mfa_pkg::SG_SUB) ? opb_r[1] - vy : opb_r[1];
          opb_r[2] <= (sg.b == mfa_pkg::SG_ADD) ? opb_r[2] + vz :
                      (sg.b == mfa_pkg::SG_SUB) ? opb_r[2] - vz : opb_r[2];
          opc_r[0] <= (sg.c == mfa_pkg::SG_ADD) ? opc_r[0] + vx :
                      (sg.c == mfa_pkg::SG_SUB) ? opc_r[0] - vx : opc_r[0];
          opc_r[1] <= (sg.c == mfa_pkg::SG_ADD) ? opc_r[1] + vy :
                      (sg.c == mfa_pkg::SG_SUB) ? opc_r[1] - vy : opc_r[1];
          opc_r[2] <= (sg.c == mfa_pkg::SG_ADD) ? opc_r[2] + vz :
                      (sg.c == mfa_pkg::SG_SUB) ? opc_r[2] - vz : opc_r[2];
        end
      end
      mfa_pkg::ST_CROSS: begin
        if (mul_done) begin
          if (!t_r) begin
            tmp_r <= mul_p[XW-1:0];
          end else begin
            case (ci_r)
              2'd0:    pv_r[k_r] <= tmp_r - mul_p[XW-1:0];
              2'd1:    qv_r[k_r] <= tmp_r - mul_p[XW-1:0];
              default: rv_r[k_r] <= tmp_r - mul_p[XW-1:0];
            endcase
          end
        end
      end
      mfa_pkg::ST_SCALE: begin
        if (mul_done) y_r <= (p_ext <<< 16) + mul_p[YW-1:0];
      end
      mfa_pkg::ST_SQUARE: begin
        if (mul_done) sumsq_r <= sumsq_r + mul_p[SW-1:0];
      end
      mfa_pkg::ST_ROOT: begin
        if (root_done) begin
          acc_r   <= acc_r + AW'(root_val);
          sumsq_r <= '0;
          for (int i = 0; i < 3; i++) begin
            opa_r[i] <= '0; opb_r[i] <= '0; opc_r[i] <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  // scale, clamp and hold the result
  assign shifted = quad ? (acc_r >> mfa_pkg::QUAD_SHIFT) : (acc_r >> mfa_pkg::TRI_SHIFT);
  assign over    = |shifted[AW-1:AREA_W];

  always_ff @(posedge clk) begin
    if (state_r == mfa_pkg::ST_DONE && state_nxt == mfa_pkg::ST_IDLE) begin
      res_unsup_r <= (mode_r == mfa_pkg::MODE_NONE);
      res_sat_r   <= (mode_r != mfa_pkg::MODE_NONE) && over;
      res_area_r  <= (mode_r == mfa_pkg::MODE_NONE) ? '0 :
                     over ? {AREA_W{1'b1}} : shifted[AREA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (state_r == mfa_pkg::ST_DONE && state_nxt == mfa_pkg::ST_IDLE) begin
      res_vld_r <= 1'b1;
    end else if (res_rdy) begin
      res_vld_r <= 1'b0;
    end
  end

  assign res_vld   = res_vld_r;
  assign res_area  = res_area_r;
  assign res_unsup = res_unsup_r;
  assign res_sat   = res_sat_r;

  mfa_mul #(.W(YW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  mfa_root #(.RW(YW)) u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .n     (sumsq_r),
    .done  (root_done),
    .root  (root_val)
  );

`ifndef SYNTHESIS
  a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_start && root_start)) else $error("both units started");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == mfa_pkg::ST_IDLE) else $error("pop outside idle");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_done || root_done) |-> busy_r) else $error("unit done while not busy");
`endif

endmodule
`default_nettype wire

### hdl/mesh_face_area.sv
// Surface face area: vertices stream in one word each; the word flagged tlast
// closes the face and yields one area word. Three- and seven-node faces give half
// the corner triangle's cross-product length, six-node faces sum four
// sub-triangles, four-node faces use 2x2 Gauss quadrature; other counts return 0
// with the unsupported flag. A vertex word is taken into a two-word
// queue; the back end drains that queue only between faces, so while a face is
// computed at most two more words are taken and the input then stalls. A face
// result is computed by one serial multiplier and one serial square root, each
// of width YW, YW = 2*COORD_BITS+22 (70 at the default). No clearing pass is
// needed after reset.
// Depends on mfa_pkg, mfa_front and mfa_back.
`default_nettype none
module mesh_face_area #(
  parameter int STORED_VERTICES = 6,
  parameter int COORD_BITS      = 24
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // vertex_x, vertex_y, vertex_z, face_nodes, zero pad
  input  wire logic [((3*COORD_BITS+4+7)/8)*8-1:0]    in_tdata,
  input  wire logic                                   in_tlast,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // area
  output logic [mfa_pkg::AREA_W-1:0]                  out_tdata,
  // unsupported, saturated
  output logic [1:0]                                  out_tuser
);

  localparam int C = COORD_BITS;

  logic           q_vld, q_pop;
  logic [3*C-1:0] q_xyz;
  mfa_pkg::tag_t  q_tag;
  logic           res_unsup, res_sat;

  mfa_front #(.C(C)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_tvalid),
    .in_rdy   (in_tready),
    .in_xyz   (in_tdata[3*C-1:0]),
    .in_nodes (in_tdata[3*C+3:3*C]),
    .in_last  (in_tlast),
    .q_vld    (q_vld),
    .q_pop    (q_pop),
    .q_xyz    (q_xyz),
    .q_tag    (q_tag)
  );

  mfa_back #(.N(STORED_VERTICES), .C(C)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_pop     (q_pop),
    .q_xyz     (q_xyz),
    .q_tag     (q_tag),
    .res_rdy   (out_tready),
    .res_vld   (out_tvalid),
    .res_area  (out_tdata),
    .res_unsup (res_unsup),
    .res_sat   (res_sat)
  );

  assign out_tuser = {res_sat, res_unsup};

`ifndef SYNTHESIS
  a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tdata == '0) else $error("unsupported with area");
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> &out_tdata) else $error("saturated not clamped");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1])) else $error("both flags set");
`endif

endmodule
`default_nettype wire

### dv/mesh_face_area_tb.sv
// Self-checking testbench for mesh_face_area: streams vertex words, predicts each face
// area with an exact integer model and compares the area words field by field.
// Depends on mfa_pkg and mesh_face_area.
`timescale 1ns / 1ps
`default_nettype none
module mesh_face_area_tb;

  localparam int CB     = 24;
  localparam int NV     = 6;
  localparam int DW     = ((3*CB+4+7)/8)*8;
  localparam int LIMIT  = 200000;
  localparam logic [47:0] AREA_TOP = 48'hFFFF_FFFF_FFFF;
  localparam logic signed [255:0] INV_RT3 = 256'sd37837;

  typedef struct {
    logic [CB-1:0] x, y, z;
    logic [3:0]    nodes;
    logic          last;
  } vertex_t;

  typedef struct {
    logic [47:0] area;
    logic        unsup;
    logic        sat;
  } area_word_t;

  typedef logic signed [255:0] wide_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tlast = 1'b0, out_tready = 1'b0;
  logic [DW-1:0] in_tdata = '0;
  logic in_tready, out_tvalid;
  logic [47:0] out_tdata;
  logic [1:0] out_tuser;

  vertex_t    pending_vertices[$];
  area_word_t expected_areas[$];
  int mismatches = 0, faces_seen = 0, stall_cycles = 0;
  int send_idle_pct = 13, recv_idle_pct = 85;
  bit stim_done = 0, hold_sender = 0;

  // predictor state
  logic signed [CB-1:0] vstore_x[NV], vstore_y[NV], vstore_z[NV];
  int vcount = 0;

  mesh_face_area #(.STORED_VERTICES(NV), .COORD_BITS(CB)) i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic wide_t isqrt(input wide_t n);
    wide_t r, b;
    r = 0;
    b = wide_t'(1) <<< 252;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic wide_t cross_len(input wide_t a[3], input wide_t b[3]);
    wide_t c0, c1, c2;
    c0 = a[1]*b[2] - a[2]*b[1];
    c1 = a[2]*b[0] - a[0]*b[2];
    c2 = a[0]*b[1] - a[1]*b[0];
    return isqrt(c0*c0 + c1*c1 + c2*c2);
  endfunction

  function automatic wide_t vcoord(input int k, input int d);
    case (d)
      0: return wide_t'(vstore_x[k]);
      1: return wide_t'(vstore_y[k]);
      default: return wide_t'(vstore_z[k]);
    endcase
  endfunction

  function automatic wide_t tri_term(input int a, input int b, input int c);
    wide_t d1[3], d2[3];
    for (int i = 0; i < 3; i++) begin
      d1[i] = vcoord(b, i) - vcoord(a, i);
      d2[i] = vcoord(c, i) - vcoord(a, i);
    end
    return cross_len(d1, d2);
  endfunction

  function automatic wide_t quad_area();
    wide_t u[3], w[3], v[3], p[3], q[3], r[3], y[3], acc;
    int sr, ss;
    for (int i = 0; i < 3; i++) begin
      u[i] = vcoord(1, i) - vcoord(0, i) + vcoord(2, i) - vcoord(3, i);
      w[i] = vcoord(3, i) - vcoord(0, i) + vcoord(2, i) - vcoord(1, i);
      v[i] = vcoord(0, i) - vcoord(1, i) + vcoord(2, i) - vcoord(3, i);
    end
    for (int i = 0; i < 3; i++) begin
      int j, k;
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      p[i] = u[j]*w[k] - u[k]*w[j];
      q[i] = u[j]*v[k] - u[k]*v[j];
      r[i] = v[j]*w[k] - v[k]*w[j];
    end
    acc = 0;
    for (int n = 0; n < 4; n++) begin
      sr = (n == 1 || n == 2) ? 1 : -1;
      ss = (n >= 2) ? 1 : -1;
      for (int i = 0; i < 3; i++) y[i] = p[i]*65536 + INV_RT3*(sr*q[i] + ss*r[i]);
      acc = acc + isqrt(y[0]*y[0] + y[1]*y[1] + y[2]*y[2]);
    end
    return acc >>> 20;
  endfunction

  // advance the predictor by one accepted vertex word
  function automatic void predict_face(input vertex_t vx);
    area_word_t res;
    wide_t acc;
    mfa_pkg::mode_t m;
    if (vcount < NV) begin
      vstore_x[vcount] = vx.x;
      vstore_y[vcount] = vx.y;
      vstore_z[vcount] = vx.z;
      vcount++;
    end
    if (!vx.last) return;
    vcount = 0;
    res = '{area: '0, unsup: 1'b0, sat: 1'b0};
    m = mfa_pkg::classify(vx.nodes);
    case (m)
      mfa_pkg::MODE_TRI:  acc = tri_term(0, 1, 2) >>> 1;
      mfa_pkg::MODE_HEX:  acc = (tri_term(0, 3, 5) + tri_term(3, 1, 4) + tri_term(2, 5, 4)
                                 + tri_term(3, 4, 5)) >>> 1;
      mfa_pkg::MODE_QUAD: acc = quad_area();
      default:            acc = 0;
    endcase
    if (m == mfa_pkg::MODE_NONE) res.unsup = 1'b1;
    else if (acc > wide_t'(AREA_TOP)) begin
      res.area = AREA_TOP;
      res.sat = 1'b1;
    end else res.area = acc[47:0];
    expected_areas.insert(expected_areas.size(), res);
  endfunction

  // drive vertex words from the pending queue
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_face(pending_vertices.pop_front());
      if ((!in_tvalid || in_tready) ) begin
        if (pending_vertices.size() != 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= DW'({pending_vertices[0].nodes, pending_vertices[0].z,
                            pending_vertices[0].y, pending_vertices[0].x});
          in_tlast  <= pending_vertices[0].last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // check area words and stall the receiver
  always @(posedge clk) begin
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        faces_seen++;
        if (expected_areas.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected area word %h", out_tdata);
        end else begin
          area_word_t e;
          e = expected_areas.pop_front();
          if (e.area !== out_tdata || e.unsup !== out_tuser[0] || e.sat !== out_tuser[1])
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("area mismatch: exp %h/%b/%b got %h/%b/%b", e.area, e.unsup,
                       e.sat, out_tdata, out_tuser[0], out_tuser[1]);
          end
        end
      end
      // watchdog on cycles with no accepted word
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
      else if (!stim_done || expected_areas.size() != 0) begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= LIMIT) begin
          $display("mesh_face_area_tb: FAIL");
          $finish;
        end
      end
    end
  end

  function automatic logic [CB-1:0] rand_coord();
    case ($urandom_range(5))
      0: return {1'b0, {(CB-1){1'b1}}};
      1: return {1'b1, {(CB-1){1'b0}}};
      2: return CB'($urandom_range(4095)) - CB'(2048);
      default: return CB'($urandom);
    endcase
  endfunction

  task automatic queue_face(input logic [3:0] nodes, input int nverts, input int mode);
    vertex_t vx;
    for (int i = 0; i < nverts; i++) begin
      case (mode)
        1: vx.x = {1'b0, {(CB-1){1'b1}}};
        2: vx.x = {1'b1, {(CB-1){1'b0}}};
        default: vx.x = rand_coord();
      endcase
      vx.y = (mode == 0) ? rand_coord() : ((i % 2) ? {1'b1, {(CB-1){1'b0}}} : '1 >> 1);
      vx.z = (mode == 0) ? rand_coord() : ((i == 1) ? '1 >> 1 : '0);
      vx.nodes = (i == nverts - 1) ? nodes : 4'($urandom);
      vx.last = (i == nverts - 1);
      pending_vertices.insert(pending_vertices.size(), vx);
    end
  endtask

  task automatic drain();
    while (pending_vertices.size() != 0 || in_tvalid || expected_areas.size() != 0)
      @(posedge clk);
    repeat (4000) @(posedge clk);
  endtask

  int n_items;
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // a full hex face first, so every store entry is written
    queue_face(4'd6, 6, 1);
    queue_face(4'd6, 6, 2);
    queue_face(4'd3, 3, 1);
    queue_face(4'd4, 4, 1);
    queue_face(4'd7, 7, 0);
    queue_face(4'd0, 1, 0);
    queue_face(4'd15, 2, 0);
    queue_face(4'd3, 9, 0);
    queue_face(4'd4, 2, 0);
    drain();
    // hold the sender with a face queued, then release it
    hold_sender = 1;
    queue_face(4'd3, 3, 0);
    repeat (50) @(posedge clk);
    hold_sender = 0;
    n_items = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 85 : 0;
      recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 13 : 0;
      for (int f = 0; f < 52; f++) begin
        int r, nv;
        logic [3:0] nd;
        r = $urandom_range(9);
        nd = (r < 3) ? 4'd3 : (r < 5) ? 4'd4 : (r < 7) ? 4'd6 : (r < 8) ? 4'd7 : 4'($urandom);
        nv = ($urandom_range(9) == 0) ? $urandom_range(1, 9) : (nd == 4'd7 ? 7 : nd);
        if (nv < 1 || nv > 9) nv = 3;
        queue_face(nd, nv, 0);
        n_items += nv;
      end
      drain();
    end
    stim_done = 1;
    $display("Covered %0d faces (%0d random vertex words): tri, hex, quad, seven-node,",
             faces_seen, n_items);
    $display("unsupported counts, short and long faces, coordinate extremes, three idling phases.");
    if (mismatches == 0) $display("mesh_face_area_tb: PASS");
    else $display("mesh_face_area_tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

### mesh_face_area.f
hdl/mfa_pkg.sv
hdl/mfa_front.sv
hdl/mfa_mul.sv
hdl/mfa_root.sv
hdl/mfa_back.sv
hdl/mesh_face_area.sv
dv/mesh_face_area_tb.sv
